// ----- sv/sgcs_pkg.sv -----
// sgcs_pkg: shared types and codes for the spatial grid counting sort block
// no dependencies

package sgcs_pkg;

   typedef enum logic [1:0] {
      CMD_ADD      = 2'd0,
      CMD_BUILD    = 2'd1,
      CMD_RD_START = 2'd2,
      CMD_RD_SLOT  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_BAD   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_GRID_COLS  = 2'd0,
      CSR_CELL_COUNT = 2'd1,
      CSR_COL_SCALE  = 2'd2,
      CSR_ROW_SCALE  = 2'd3
   } csr_type;

   localparam int DATA_W = 11;

   // classified command as it leaves the front end
   typedef struct packed {
      cmd_type           cmd;
      logic [DATA_W-1:0] addr;
      logic              oor;
   } op_type;

endpackage

// ----- sv/sgcs_front.sv -----
// sgcs_front: accepts items and computes the linear grid cell of add commands
// depends on sgcs_pkg

module sgcs_front #(
   parameter int CW = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_cmd,
   input  logic [15:0]            req_x_pos,
   input  logic [15:0]            req_y_pos,
   input  logic [10:0]            req_addr,
   input  logic [10:0]            grid_cols,
   input  logic [15:0]            col_scale,
   input  logic [15:0]            row_scale,
   input  logic [CW-1:0]          cell_lim,
   output logic                   q_valid,
   input  logic                   q_ready,
   output sgcs_pkg::op_type       q_op,
   output logic [CW-1:0]          q_cell
);

   logic             a_valid_ff, a_valid_in;
   sgcs_pkg::cmd_type a_cmd_ff;
   logic [10:0]      a_addr_ff;
   logic [15:0]      a_cx_ff, a_cy_ff;
   logic             b_valid_ff, b_valid_in;
   sgcs_pkg::op_type b_op_ff;
   logic [CW-1:0]    b_cell_ff;
   logic             a_adv, b_adv;
   logic [31:0]      x_prod, y_prod;
   logic [27:0]      cell_full;

   assign b_adv     = !b_valid_ff || q_ready;
   assign a_adv     = !a_valid_ff || b_adv;
   assign req_ready = a_adv;
   assign x_prod    = req_x_pos * col_scale;
   assign y_prod    = req_y_pos * row_scale;
   assign cell_full = 28'(a_cy_ff) * 28'(grid_cols) + 28'(a_cx_ff);

   assign a_valid_in = a_adv ? req_valid : a_valid_ff;
   assign b_valid_in = b_adv ? a_valid_ff : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv) begin
         a_cmd_ff  <= sgcs_pkg::cmd_type'(req_cmd);
         a_addr_ff <= req_addr;
         a_cx_ff   <= x_prod[31:16];
         a_cy_ff   <= y_prod[31:16];
      end
      if (b_adv) begin
         b_op_ff.cmd  <= a_cmd_ff;
         b_op_ff.addr <= a_addr_ff;
         b_op_ff.oor  <= cell_full >= 28'(cell_lim);
         b_cell_ff    <= CW'(cell_full);
      end
   end

   assign q_valid = b_valid_ff;
   assign q_op    = b_op_ff;
   assign q_cell  = b_cell_ff;

endmodule

// ----- sv/sgcs_queue.sv -----
// sgcs_queue: short first-in first-out queue between front and back
// no dependencies

module sgcs_queue #(
   parameter int W     = 8,
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);

   localparam int PW = $clog2(DEPTH);

   logic [W-1:0]  slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]   count_ff;
   logic          push, pop;

   assign in_ready  = count_ff != (PW+1)'(DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + PW'(1);
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + PW'(1);
         count_ff <= count_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= in_data;
   end

endmodule

// ----- sv/sgcs_back.sv -----
// sgcs_back: item store, counting sort build sequencer and result register
// depends on sgcs_pkg

module sgcs_back #(
   parameter int MAX_ITEMS = 1024,
   parameter int MAX_CELLS = 1024,
   parameter int CW        = 11
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  sgcs_pkg::op_type  q_op,
   input  logic [CW-1:0]     q_cell,
   input  logic [CW-1:0]     cell_lim,
   input  logic              cfg_clear,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [10:0]       rsp_data
);

   localparam int IW = $clog2(MAX_ITEMS);
   localparam int TW = $clog2(MAX_ITEMS + 1);
   localparam int XW = (CW > TW) ? CW : TW;

   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_RD    = 12'b000000000010,
      S_CLR   = 12'b000000000100,
      S_CNT_A = 12'b000000001000,
      S_CNT_B = 12'b000000010000,
      S_CNT_C = 12'b000000100000,
      S_PFX_A = 12'b000001000000,
      S_PFX_B = 12'b000010000000,
      S_SCT_A = 12'b000100000000,
      S_SCT_B = 12'b001000000000,
      S_SCT_C = 12'b010000000000,
      S_DONE  = 12'b100000000000
   } state_type;

   logic [CW-1:0] item_mem [MAX_ITEMS];
   logic [TW-1:0] tbl_mem  [MAX_CELLS+1];
   logic [TW-1:0] cur_mem  [MAX_CELLS+1];
   logic [IW-1:0] srt_mem  [MAX_ITEMS];

   state_type     state_ff, state_in;
   logic [XW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cell_ff, cell_in;
   logic [TW-1:0] sum_ff, sum_in;
   logic [TW-1:0] total_ff, total_in;
   logic          built_ff, built_in;
   logic          slot_rd_ff, slot_rd_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [10:0]   rsp_data_ff, rsp_data_in;

   logic          it_re, it_we;
   logic [IW-1:0] it_ra, it_wa;
   logic [CW-1:0] it_wd, it_rd_ff;
   logic          tbl_re, tbl_we;
   logic [CW-1:0] tbl_ra, tbl_wa;
   logic [TW-1:0] tbl_wd, tbl_rd_ff;
   logic          cur_re, cur_we;
   logic [CW-1:0] cur_ra, cur_wa;
   logic [TW-1:0] cur_wd, cur_rd_ff;
   logic          srt_re, srt_we;
   logic [IW-1:0] srt_ra, srt_wa;
   logic [IW-1:0] srt_wd, srt_rd_ff;

   logic          out_free, emit;
   logic [CW-1:0] clamp_cell;
   logic [XW-1:0] idx_next;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign q_ready    = (state_ff == S_IDLE) && out_free;
   assign clamp_cell = (it_rd_ff < cell_lim) ? it_rd_ff : cell_lim;
   assign idx_next   = idx_ff + XW'(1);

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cell_in       = cell_ff;
      sum_in        = sum_ff;
      total_in      = total_ff;
      built_in      = built_ff;
      slot_rd_in    = slot_rd_ff;
      emit          = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      it_re = 1'b0; it_ra = IW'(idx_ff); it_we = 1'b0; it_wa = IW'(total_ff); it_wd = q_cell;
      tbl_re = 1'b0; tbl_ra = CW'(idx_ff); tbl_we = 1'b0; tbl_wa = CW'(idx_ff); tbl_wd = '0;
      cur_re = 1'b0; cur_ra = clamp_cell; cur_we = 1'b0; cur_wa = CW'(idx_ff); cur_wd = sum_ff;
      srt_re = 1'b0; srt_ra = IW'(q_op.addr); srt_we = 1'b0; srt_wa = IW'(cur_rd_ff);
      srt_wd = IW'(idx_ff);
      if (cfg_clear) built_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               unique case (q_op.cmd)
                  sgcs_pkg::CMD_ADD: begin
                     emit        = 1'b1;
                     rsp_data_in = 11'(total_ff);
                     if (q_op.oor) begin
                        rsp_status_in = sgcs_pkg::ST_RANGE;
                     end else if (total_ff == TW'(MAX_ITEMS)) begin
                        rsp_status_in = sgcs_pkg::ST_FULL;
                     end else begin
                        it_we         = 1'b1;
                        total_in      = total_ff + TW'(1);
                        built_in      = 1'b0;
                        rsp_status_in = sgcs_pkg::ST_OK;
                        rsp_data_in   = 11'(total_ff + TW'(1));
                     end
                  end
                  sgcs_pkg::CMD_BUILD: begin
                     idx_in   = '0;
                     state_in = S_CLR;
                  end
                  sgcs_pkg::CMD_RD_START: begin
                     if (!built_ff || 32'(q_op.addr) > 32'(cell_lim)) begin
                        emit          = 1'b1;
                        rsp_status_in = sgcs_pkg::ST_BAD;
                        rsp_data_in   = '0;
                     end else begin
                        tbl_re     = 1'b1;
                        tbl_ra     = CW'(q_op.addr);
                        slot_rd_in = 1'b0;
                        state_in   = S_RD;
                     end
                  end
                  sgcs_pkg::CMD_RD_SLOT: begin
                     if (!built_ff || 32'(q_op.addr) >= 32'(total_ff)) begin
                        emit          = 1'b1;
                        rsp_status_in = sgcs_pkg::ST_BAD;
                        rsp_data_in   = '0;
                     end else begin
                        srt_re     = 1'b1;
                        slot_rd_in = 1'b1;
                        state_in   = S_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_RD: begin
            if (out_free) begin
               emit          = 1'b1;
               rsp_status_in = sgcs_pkg::ST_OK;
               rsp_data_in   = slot_rd_ff ? 11'(srt_rd_ff) : 11'(tbl_rd_ff);
               state_in      = S_IDLE;
            end
         end
         S_CLR: begin
            tbl_we = 1'b1;
            if (idx_ff == XW'(cell_lim)) begin
               idx_in   = '0;
               sum_in   = '0;
               state_in = (total_ff == '0) ? S_PFX_A : S_CNT_A;
            end else begin
               idx_in = idx_next;
            end
         end
         S_CNT_A: begin
            it_re    = 1'b1;
            state_in = S_CNT_B;
         end
         S_CNT_B: begin
            tbl_re   = 1'b1;
            tbl_ra   = clamp_cell;
            cell_in  = clamp_cell;
            state_in = S_CNT_C;
         end
         S_CNT_C: begin
            tbl_we = 1'b1;
            tbl_wa = cell_ff;
            tbl_wd = tbl_rd_ff + TW'(1);
            if (idx_next == XW'(total_ff)) begin
               idx_in   = '0;
               state_in = S_PFX_A;
            end else begin
               idx_in   = idx_next;
               state_in = S_CNT_A;
            end
         end
         S_PFX_A: begin
            tbl_re   = 1'b1;
            state_in = S_PFX_B;
         end
         S_PFX_B: begin
            tbl_we = 1'b1;
            tbl_wd = sum_ff;
            cur_we = 1'b1;
            sum_in = sum_ff + tbl_rd_ff;
            if (idx_ff == XW'(cell_lim)) begin
               idx_in   = '0;
               state_in = (total_ff == '0) ? S_DONE : S_SCT_A;
            end else begin
               idx_in   = idx_next;
               state_in = S_PFX_A;
            end
         end
         S_SCT_A: begin
            it_re    = 1'b1;
            state_in = S_SCT_B;
         end
         S_SCT_B: begin
            cur_re   = 1'b1;
            cell_in  = clamp_cell;
            state_in = S_SCT_C;
         end
         S_SCT_C: begin
            srt_we = 1'b1;
            cur_we = 1'b1;
            cur_wa = cell_ff;
            cur_wd = cur_rd_ff + TW'(1);
            if (idx_next == XW'(total_ff)) begin
               state_in = S_DONE;
            end else begin
               idx_in   = idx_next;
               state_in = S_SCT_A;
            end
         end
         S_DONE: begin
            if (out_free) begin
               emit          = 1'b1;
               built_in      = 1'b1;
               rsp_status_in = sgcs_pkg::ST_OK;
               rsp_data_in   = 11'(total_ff);
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cell_ff    <= cell_in;
      sum_ff     <= sum_in;
      slot_rd_ff <= slot_rd_in;
      if (emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   // item cell store
   always_ff @(posedge clock) begin
      if (it_we) item_mem[it_wa] <= it_wd;
      if (it_re) it_rd_ff <= item_mem[it_ra];
   end

   // cell start table
   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
      if (tbl_re) tbl_rd_ff <= tbl_mem[tbl_ra];
   end

   // per cell scatter cursor
   always_ff @(posedge clock) begin
      if (cur_we) cur_mem[cur_wa] <= cur_wd;
      if (cur_re) cur_rd_ff <= cur_mem[cur_ra];
   end

   // sorted slot table
   always_ff @(posedge clock) begin
      if (srt_we) srt_mem[srt_wa] <= srt_wd;
      if (srt_re) srt_rd_ff <= srt_mem[srt_ra];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ----- sv/spatial_grid_counting_sort.sv -----
// add: one add item per cycle while the result output is not stalled
// read cell start or sorted slot: memory read, then result; next item waits for it
// build: clear, count, prefix sum and scatter passes, run by the build sequencer
// reset clears control state, the item count and the built flag; no clearing pass
// spatial_grid_counting_sort: config registers, front end, queue and back end
// depends on sgcs_pkg, sgcs_front, sgcs_queue, sgcs_back

module spatial_grid_counting_sort #(
   parameter int MAX_ITEMS = 1024,
   parameter int MAX_CELLS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_x_pos,
   input  logic [15:0] req_y_pos,
   input  logic [10:0] req_addr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [10:0] rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int CW = $clog2(MAX_CELLS + 1);
   localparam int QW = $bits(sgcs_pkg::op_type) + CW;

   logic [10:0]      grid_cols_ff, cell_count_ff;
   logic [15:0]      col_scale_ff, row_scale_ff;
   logic [CW-1:0]    cell_lim;
   logic             f_valid, f_ready, b_valid, b_ready;
   sgcs_pkg::op_type f_op, b_op;
   logic [CW-1:0]    f_cell, b_cell;
   logic [QW-1:0]    b_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff  <= 11'd32;
         cell_count_ff <= 11'd1024;
         col_scale_ff  <= 16'd256;
         row_scale_ff  <= 16'd256;
      end else if (csr_we) begin
         unique case (sgcs_pkg::csr_type'(csr_index))
            sgcs_pkg::CSR_GRID_COLS:  grid_cols_ff  <= csr_wdata[10:0];
            sgcs_pkg::CSR_CELL_COUNT: cell_count_ff <= csr_wdata[10:0];
            sgcs_pkg::CSR_COL_SCALE:  col_scale_ff  <= csr_wdata;
            sgcs_pkg::CSR_ROW_SCALE:  row_scale_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cell_lim = (32'(cell_count_ff) < MAX_CELLS) ? CW'(cell_count_ff) : CW'(MAX_CELLS);

   sgcs_front #(.CW(CW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .req_x_pos (req_x_pos),
      .req_y_pos (req_y_pos),
      .req_addr  (req_addr),
      .grid_cols (grid_cols_ff),
      .col_scale (col_scale_ff),
      .row_scale (row_scale_ff),
      .cell_lim  (cell_lim),
      .q_valid   (f_valid),
      .q_ready   (f_ready),
      .q_op      (f_op),
      .q_cell    (f_cell)
   );

   sgcs_queue #(.W(QW), .DEPTH(4)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   ({f_op, f_cell}),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (b_word)
   );

   assign b_op   = sgcs_pkg::op_type'(b_word[QW-1:CW]);
   assign b_cell = b_word[CW-1:0];

   sgcs_back #(.MAX_ITEMS(MAX_ITEMS), .MAX_CELLS(MAX_CELLS), .CW(CW)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (b_valid),
      .q_ready    (b_ready),
      .q_op       (b_op),
      .q_cell     (b_cell),
      .cell_lim   (cell_lim),
      .cfg_clear  (csr_we),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_status (rsp_status),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- sv/sgcs_checker.sv -----
// sgcs_checker: port level checks of the result channel, bound to the top level
// depends on sgcs_pkg and spatial_grid_counting_sort

module sgcs_checker #(
   parameter int MAX_ITEMS = 1024
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [10:0] rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sgcs_pkg::ST_FULL |-> rsp_data == 11'(MAX_ITEMS))
      else $error("store full reported below capacity");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sgcs_pkg::ST_BAD |-> rsp_data == 11'd0)
      else $error("bad address item carries data");

endmodule

bind spatial_grid_counting_sort sgcs_checker #(.MAX_ITEMS(MAX_ITEMS)) u_sgcs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_status (rsp_status),
   .rsp_data   (rsp_data)
);

// ----- sim/tb_top.sv -----
// tb_top: self-checking testbench for spatial_grid_counting_sort
// drives add, build and read items, predicts every result, checks each result in order
// depends on sgcs_pkg and spatial_grid_counting_sort
`timescale 1ns / 100ps

module tb_top;

   localparam int MAX_ITEMS = 1024;
   localparam int MAX_CELLS = 1024;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct {
      sgcs_pkg::status_type        status;
      logic [sgcs_pkg::DATA_W-1:0] data;
   } grid_rsp_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_cmd;
   logic [15:0] req_x_pos;
   logic [15:0] req_y_pos;
   logic [10:0] req_addr;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [10:0] rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   // predictor state
   logic [10:0] grid_cols_q, cell_count_q;
   logic [15:0] col_scale_q, row_scale_q;
   logic [9:0]  item_cell_mem[MAX_ITEMS];
   logic [10:0] cell_start_mem[MAX_CELLS+1];
   logic [10:0] cell_fill_mem[MAX_CELLS+1];
   logic [9:0]  sorted_mem[MAX_ITEMS];
   int          stored_total;
   bit          is_built;

   grid_rsp_type pending_rsp[$];
   int           errors = 0;
   longint       cycles = 0;
   int           burst_left = 4;
   int           rdy_mode = 0;

   spatial_grid_counting_sort #(
      .MAX_ITEMS(MAX_ITEMS),
      .MAX_CELLS(MAX_CELLS)
   ) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_x_pos(req_x_pos), .req_y_pos(req_y_pos), .req_addr(req_addr),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int cells_used();
      return (cell_count_q < MAX_CELLS) ? int'(cell_count_q) : MAX_CELLS;
   endfunction

   function automatic void sort_cells();
      int n, sum, c, cnt, slot;
      n = cells_used();
      sum = 0;
      for (int i = 0; i <= n; i++) begin
         cell_start_mem[i] = '0;
         cell_fill_mem[i] = '0;
      end
      for (int i = 0; i < stored_total; i++) begin
         c = (item_cell_mem[i] < n) ? int'(item_cell_mem[i]) : n;
         cell_start_mem[c]++;
      end
      for (int i = 0; i <= n; i++) begin
         cnt = int'(cell_start_mem[i]);
         cell_start_mem[i] = 11'(sum);
         sum += cnt;
      end
      for (int i = 0; i < stored_total; i++) begin
         c = (item_cell_mem[i] < n) ? int'(item_cell_mem[i]) : n;
         slot = int'(cell_start_mem[c]) + int'(cell_fill_mem[c]);
         cell_fill_mem[c]++;
         if (slot < MAX_ITEMS) sorted_mem[slot] = 10'(i);
      end
      is_built = 1'b1;
   endfunction

   function automatic grid_rsp_type grid_predict(sgcs_pkg::cmd_type c, logic [15:0] x,
                                                 logic [15:0] y, logic [10:0] a);
      grid_rsp_type r;
      longint unsigned cx, cy, cell_num;
      int n;
      n = cells_used();
      r.status = sgcs_pkg::ST_OK;
      r.data = '0;
      case (c)
         sgcs_pkg::CMD_ADD: begin
            cx = (longint'(x) * col_scale_q) >> 16;
            cy = (longint'(y) * row_scale_q) >> 16;
            cell_num = cy * grid_cols_q + cx;
            if (cell_num >= n) r.status = sgcs_pkg::ST_RANGE;
            else if (stored_total >= MAX_ITEMS) r.status = sgcs_pkg::ST_FULL;
            else begin
               item_cell_mem[stored_total] = cell_num[9:0];
               stored_total++;
               is_built = 1'b0;
            end
            r.data = 11'(stored_total);
         end
         sgcs_pkg::CMD_BUILD: begin
            sort_cells();
            r.data = 11'(stored_total);
         end
         sgcs_pkg::CMD_RD_START: begin
            if (!is_built || a > n) r.status = sgcs_pkg::ST_BAD;
            else r.data = cell_start_mem[a];
         end
         default: begin
            if (!is_built || a >= stored_total) r.status = sgcs_pkg::ST_BAD;
            else r.data = 11'(sorted_mem[a]);
         end
      endcase
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result status %0d data %0d", $time, rsp_status, rsp_data);
            errors++;
         end else begin
            if (rsp_status !== pending_rsp[0].status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        pending_rsp[0].status, rsp_status);
               errors++;
            end
            if (rsp_data !== pending_rsp[0].data) begin
               $display("%0t: data expected %0d actual %0d", $time,
                        pending_rsp[0].data, rsp_data);
               errors++;
            end
            void'(pending_rsp.pop_front());
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (cycles % 64 == 0) rdy_mode <= $urandom_range(0, 3);
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         case (rdy_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_item(sgcs_pkg::cmd_type c, logic [15:0] x, logic [15:0] y,
                            logic [10:0] a);
      req_valid <= 1'b1;
      req_cmd <= c;
      req_x_pos <= x;
      req_y_pos <= y;
      req_addr <= a;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(grid_predict(c, x, y, a));
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(sgcs_pkg::csr_type idx, logic [15:0] value);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         sgcs_pkg::CSR_GRID_COLS: grid_cols_q = value[10:0];
         sgcs_pkg::CSR_CELL_COUNT: cell_count_q = value[10:0];
         sgcs_pkg::CSR_COL_SCALE: col_scale_q = value;
         default: row_scale_q = value;
      endcase
      is_built = 1'b0;
   endtask

   task automatic set_grid(logic [10:0] cols, logic [10:0] cnt, logic [15:0] cs,
                           logic [15:0] rs);
      write_csr(sgcs_pkg::CSR_GRID_COLS, 16'(cols));
      write_csr(sgcs_pkg::CSR_CELL_COUNT, 16'(cnt));
      write_csr(sgcs_pkg::CSR_COL_SCALE, cs);
      write_csr(sgcs_pkg::CSR_ROW_SCALE, rs);
   endtask

   task automatic send_random();
      int r, m;
      logic [15:0] x, y;
      logic [10:0] a;
      r = $urandom_range(0, 99);
      m = $urandom_range(3, 16);
      x = 16'($urandom & ((32'd1 << m) - 1));
      m = $urandom_range(3, 16);
      y = 16'($urandom & ((32'd1 << m) - 1));
      if (r < 2) send_item(sgcs_pkg::CMD_BUILD, x, y, 11'($urandom));
      else if (r < 60) send_item(sgcs_pkg::CMD_ADD, x, y, 11'($urandom));
      else begin
         if ($urandom_range(0, 9) == 0) a = 11'($urandom);
         else if (r < 80) a = 11'($urandom_range(0, cells_used() + 1));
         else a = 11'($urandom_range(0, stored_total));
         send_item((r < 80) ? sgcs_pkg::CMD_RD_START : sgcs_pkg::CMD_RD_SLOT, x, y, a);
      end
   endtask

   task automatic test_directed();
      send_item(sgcs_pkg::CMD_RD_START, 16'h0, 16'h0, 11'd0);
      send_item(sgcs_pkg::CMD_RD_SLOT, 16'h0, 16'h0, 11'd0);
      send_item(sgcs_pkg::CMD_ADD, 16'h0000, 16'h0000, 11'd0);
      send_item(sgcs_pkg::CMD_ADD, 16'hffff, 16'hffff, 11'h7ff);
      send_item(sgcs_pkg::CMD_ADD, 16'h2800, 16'h0100, 11'd0);   // column spills past row end
      send_item(sgcs_pkg::CMD_ADD, 16'h1f80, 16'h1f80, 11'd0);
      send_item(sgcs_pkg::CMD_ADD, 16'h0000, 16'h2000, 11'd0);   // row 32 is out of range
      send_item(sgcs_pkg::CMD_ADD, 16'h0100, 16'h0000, 11'd0);
      send_item(sgcs_pkg::CMD_BUILD, 16'h0, 16'h0, 11'd0);
      for (int i = 0; i < 3; i++) send_item(sgcs_pkg::CMD_RD_START, 16'h0, 16'h0, 11'(i));
      send_item(sgcs_pkg::CMD_RD_START, 16'h0, 16'h0, 11'd1024);   // guard cell
      send_item(sgcs_pkg::CMD_RD_START, 16'h0, 16'h0, 11'd1025);
      send_item(sgcs_pkg::CMD_RD_START, 16'h0, 16'h0, 11'h7ff);
      for (int i = 0; i <= 4; i++) send_item(sgcs_pkg::CMD_RD_SLOT, 16'h0, 16'h0, 11'(i));
      send_item(sgcs_pkg::CMD_RD_SLOT, 16'h0, 16'h0, 11'h7ff);
   endtask

   task automatic test_config_sweep();
      logic [10:0] cols[5] = '{11'd1, 11'd1024, 11'd1024, 11'd7, 11'd32};
      logic [10:0] cnts[5] = '{11'd1024, 11'd1024, 11'd1, 11'd50, 11'd600};
      logic [15:0] css[5]  = '{16'd256, 16'd65535, 16'd1, 16'd700, 16'd128};
      logic [15:0] rss[5]  = '{16'd256, 16'd65535, 16'd1, 16'd300, 16'd2000};
      for (int p = 0; p < 5; p++) begin
         set_grid(cols[p], cnts[p], css[p], rss[p]);
         for (int i = 0; i < 150; i++) send_random();
         send_item(sgcs_pkg::CMD_BUILD, 16'h0, 16'h0, 11'd0);
         for (int i = 0; i < 10; i++) send_random();
      end
      set_grid(11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)),
               16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
      for (int i = 0; i < 60; i++) send_random();
   endtask

   task automatic test_shrink();
      set_grid(11'd32, 11'd1024, 16'd256, 16'd256);
      for (int i = 0; i < 30; i++)
         send_item(sgcs_pkg::CMD_ADD, 16'($urandom & 32'h1fff), 16'($urandom & 32'h1fff),
                   11'd0);
      write_csr(sgcs_pkg::CSR_CELL_COUNT, 16'd20);
      send_item(sgcs_pkg::CMD_BUILD, 16'h0, 16'h0, 11'd0);
      for (int i = 0; i <= 21; i++) send_item(sgcs_pkg::CMD_RD_START, 16'h0, 16'h0, 11'(i));
      for (int i = 0; i < 20; i++)
         send_item(sgcs_pkg::CMD_RD_SLOT, 16'h0, 16'h0, 11'($urandom_range(0, stored_total)));
   endtask

   task automatic test_store_full();
      set_grid(11'd16, 11'd1024, 16'd512, 16'd512);
      while (stored_total < MAX_ITEMS)
         send_item(sgcs_pkg::CMD_ADD, 16'($urandom & 32'h0fff), 16'($urandom & 32'h0fff),
                   11'd0);
      for (int i = 0; i < 4; i++) send_item(sgcs_pkg::CMD_ADD, 16'h0, 16'h0, 11'd0);
      send_item(sgcs_pkg::CMD_ADD, 16'hffff, 16'hffff, 11'd0);
      send_item(sgcs_pkg::CMD_BUILD, 16'h0, 16'h0, 11'd0);
      send_item(sgcs_pkg::CMD_RD_SLOT, 16'h0, 16'h0, 11'd1023);
      send_item(sgcs_pkg::CMD_RD_SLOT, 16'h0, 16'h0, 11'd1024);
      send_item(sgcs_pkg::CMD_RD_START, 16'h0, 16'h0, 11'd1024);
      for (int i = 0; i < 40; i++) send_random();
   endtask

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_cmd <= sgcs_pkg::CMD_ADD;
      req_x_pos <= '0;
      req_y_pos <= '0;
      req_addr <= '0;
      csr_we <= 1'b0;
      csr_index <= sgcs_pkg::CSR_GRID_COLS;
      csr_wdata <= '0;
      grid_cols_q = 11'd32;
      cell_count_q = 11'd1024;
      col_scale_q = 16'd256;
      row_scale_q = 16'd256;
      stored_total = 0;
      is_built = 1'b0;
      for (int i = 0; i <= MAX_CELLS; i++) cell_start_mem[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_idle();
      test_config_sweep();
      test_shrink();
      test_store_full();
      wait_idle();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
